>>> rtl/pak_name_charset_codec_unit_defines.svh
// ----------------------------------------------------------------------------
// Pak name codec assertion macros
// Shared property wrappers for the codec's checker.
// ----------------------------------------------------------------------------
`ifndef PAK_NAME_CHARSET_CODEC_UNIT_DEFINES_SVH
`define PAK_NAME_CHARSET_CODEC_UNIT_DEFINES_SVH

// Property checked at every edge outside reset.
`define PNC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pak name codec: assertion failed");

// Property checked at every edge, reset included.
`define PNC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pak name codec: assertion failed");

`endif

>>> rtl/pnc_pkg.sv
// ----------------------------------------------------------------------------
// Pak name codec package
// Code set constants and the punctuation table.
// ----------------------------------------------------------------------------
package pnc_pkg;

  typedef logic [7:0] byte_t;

  localparam byte_t PUNCT_BASE = 8'h34;
  localparam byte_t PUNCT_LAST = 8'h41;
  localparam byte_t ENC_SPACE  = 8'h0F;
  localparam byte_t ENC_LOW    = 8'h20;
  localparam byte_t ENC_OTHER  = 8'h3B;
  localparam byte_t DEC_OTHER  = 8'h2D;
  localparam byte_t ASCII_SPC  = 8'h20;
  localparam byte_t ASCII_ZERO = 8'h30;
  localparam byte_t ASCII_NINE = 8'h39;
  localparam byte_t ASCII_A    = 8'h41;
  localparam byte_t ASCII_Z    = 8'h5A;
  localparam byte_t DIG_OFFS   = 8'h20;
  localparam byte_t CAP_OFFS   = 8'h27;
  localparam byte_t CODE_DIG0  = 8'h10;
  localparam byte_t CODE_CAPA  = 8'h1A;

  localparam int PUNCT_COUNT = 14;

  typedef logic [3:0] punct_idx_t;

  // Punctuation table entry for a given index.
  function automatic byte_t punct_char(input punct_idx_t idx);
    byte_t c;
    case (idx)
      4'd0:    c = 8'h21;
      4'd1:    c = 8'h22;
      4'd2:    c = 8'h23;
      4'd3:    c = 8'h27;
      4'd4:    c = 8'h2A;
      4'd5:    c = 8'h2B;
      4'd6:    c = 8'h2C;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h2E;
      4'd9:    c = 8'h2F;
      4'd10:   c = 8'h3A;
      4'd11:   c = 8'h3D;
      4'd12:   c = 8'h3F;
      4'd13:   c = 8'h40;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/pnc_conv.sv
// ----------------------------------------------------------------------------
// Pak name codec byte converter
// Combinational mapping of one byte in either direction.
// ----------------------------------------------------------------------------
module pnc_conv (
  input  logic        mode,
  input  logic [7:0]  char_in,
  input  logic        name_ended,
  output logic [7:0]  char_out
);

  logic [7:0] enc;
  logic [7:0] dec;
  logic       hit;
  logic [3:0] hit_idx;
  logic [7:0] dec_off;

  // Parallel compare against the punctuation table.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = 0; k < pnc_pkg::PUNCT_COUNT; k++) begin
      if (!hit && char_in == pnc_pkg::punct_char(4'(k))) begin
        hit     = 1'b1;
        hit_idx = 4'(k);
      end
    end
  end

  always_comb begin
    if (char_in < pnc_pkg::ASCII_SPC) begin
      enc = 8'h00;
    end else if (char_in == pnc_pkg::ASCII_SPC) begin
      enc = pnc_pkg::ENC_SPACE;
    end else if (hit) begin
      enc = pnc_pkg::PUNCT_BASE + {4'h0, hit_idx};
    end else if (char_in < pnc_pkg::ASCII_ZERO) begin
      enc = pnc_pkg::ENC_LOW;
    end else if (char_in <= pnc_pkg::ASCII_NINE) begin
      enc = char_in - pnc_pkg::DIG_OFFS;
    end else if (char_in >= pnc_pkg::ASCII_A && char_in <= pnc_pkg::ASCII_Z) begin
      enc = char_in - pnc_pkg::CAP_OFFS;
    end else begin
      enc = pnc_pkg::ENC_OTHER;
    end
  end

  assign dec_off = char_in - pnc_pkg::PUNCT_BASE;

  always_comb begin
    if (char_in < pnc_pkg::ENC_SPACE) begin
      dec = pnc_pkg::DEC_OTHER;
    end else if (char_in == pnc_pkg::ENC_SPACE) begin
      dec = pnc_pkg::ASCII_SPC;
    end else if (char_in < pnc_pkg::CODE_CAPA) begin
      dec = char_in + pnc_pkg::DIG_OFFS;
    end else if (char_in < pnc_pkg::PUNCT_BASE) begin
      dec = char_in + pnc_pkg::CAP_OFFS;
    end else if (char_in <= pnc_pkg::PUNCT_LAST) begin
      dec = pnc_pkg::punct_char(dec_off[3:0]);
    end else begin
      dec = pnc_pkg::DEC_OTHER;
    end
  end

  assign char_out = name_ended ? 8'h00 : (mode ? dec : enc);

endmodule

>>> rtl/pak_name_charset_codec_unit.sv
// ----------------------------------------------------------------------------
// Pak name character codec
// Converts name bytes between ASCII and the pak name code set.
// ----------------------------------------------------------------------------
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid in_stall in_mode in_char             | sink
//          | in_first_char in_last_char                    |
//  out     | out_valid out_stall out_char out_end_of_name  | source
//
// One item per cycle while the output does not stall, through an input register
// and a result register; an accepted item passes the first, then the second.
// A decode item flagged last yields a second, zero result, which holds the
// result register for the terminator and so stalls the input behind it.
// Reset is synchronous and clears both stages and the end-of-name latch.
// Stall on the output holds the result register and backs up to in_stall.
// ----------------------------------------------------------------------------
module pak_name_charset_codec_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_char,
  input  logic       in_first_char,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_end_of_name
);

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_mode_r;
  logic [7:0] s1_char_r;
  logic       s1_first_r;
  logic       s1_last_r;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_eon_r, out_eon_nxt;
  logic       extra_r, extra_nxt;
  logic       zero_seen_r, zero_seen_nxt;

  logic       out_free;
  logic       in_fire;
  logic       s1_move;
  logic       ended;
  logic [7:0] conv_char;

  assign out_free = !out_valid_r || (!out_stall && !extra_r);
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // First byte restarts the name; a zero byte ends it.
  assign ended = (!s1_first_r && zero_seen_r) || (s1_char_r == 8'h00);

  pnc_conv u_conv (
    .mode       (s1_mode_r),
    .char_in    (s1_char_r),
    .name_ended (ended),
    .char_out   (conv_char)
  );

  always_comb begin
    s1_valid_nxt  = in_fire || (s1_valid_r && !s1_move);
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_eon_nxt   = out_eon_r;
    extra_nxt     = extra_r;
    zero_seen_nxt = zero_seen_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = conv_char;
      out_eon_nxt   = s1_last_r && !s1_mode_r;
      extra_nxt     = s1_last_r && s1_mode_r;
      zero_seen_nxt = ended;
    end else if (out_valid_r && !out_stall) begin
      if (extra_r) begin
        // append the terminator after a decoded name
        out_char_nxt = 8'h00;
        out_eon_nxt  = 1'b1;
        extra_nxt    = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      extra_r     <= 1'b0;
      zero_seen_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      extra_r     <= extra_nxt;
      zero_seen_r <= zero_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r  <= in_mode;
      s1_char_r  <= in_char;
      s1_first_r <= in_first_char;
      s1_last_r  <= in_last_char;
    end
    out_char_r <= out_char_nxt;
    out_eon_r  <= out_eon_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_end_of_name = out_eon_r;

endmodule

>>> rtl/pnc_checker.sv
// ----------------------------------------------------------------------------
// Pak name codec checker
// Port-level properties of the codec, bound to the top level.
// ----------------------------------------------------------------------------
`include "pak_name_charset_codec_unit_defines.svh"

module pnc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_end_of_name
);

  // A held result stays put.
  `PNC_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_char) && $stable(out_end_of_name)))

  // Input back-pressure only comes from a full result register.
  `PNC_ASSERT(a_stall_cause, in_stall |-> out_valid)

  // Nothing is shown straight after reset.
  `PNC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid)

  // An idle block never blocks its input.
  `PNC_ASSERT(a_idle_ready, (!out_valid && !in_valid) |=> !in_stall)

endmodule

bind pak_name_charset_codec_unit pnc_checker u_pnc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_char        (out_char),
  .out_end_of_name (out_end_of_name)
);

>>> test/tb_pak_name_charset_codec_unit.sv
// ----------------------------------------------------------------------------
// Pak name codec testbench
// Sends name bytes in both directions through the codec. Each accepted item
// is converted by a local predictor. Each result is checked against the
// oldest expected byte, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_pak_name_charset_codec_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_ENC = 1'b0;
  localparam logic MODE_DEC = 1'b1;
  localparam pnc_pkg::byte_t NUL_CHAR = 8'h00;
  localparam int RANDOM_ITEMS = 1600;
  localparam int MAX_GAP = 13;
  localparam int STUCK_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 8;

  // punctuation marks in code order, entry 0 in the low byte
  localparam logic [8*pnc_pkg::PUNCT_COUNT-1:0] PUNCT_SET = {
    8'h40, 8'h3F, 8'h3D, 8'h3A, 8'h2F, 8'h2E, 8'h2D,
    8'h2C, 8'h2B, 8'h2A, 8'h27, 8'h23, 8'h22, 8'h21
  };

  typedef struct packed {
    pnc_pkg::byte_t ch;
    logic           eon;
  } name_res_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic           in_mode = MODE_ENC;
  pnc_pkg::byte_t in_char = 8'h00;
  logic           in_first_char = 1'b0;
  logic           in_last_char = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  pnc_pkg::byte_t out_char;
  logic           out_end_of_name;

  name_res_t exp_chars[$];
  name_res_t want;
  logic zero_latch = 1'b0;
  bit   in_gaps = 1'b1;
  bit   out_gaps = 1'b1;
  int   hold_left = 0;
  int   stuck_cycles = 0;
  int   n_items = 0;
  int   n_results = 0;
  int   n_terminators = 0;
  int   n_zero_bytes = 0;
  int   n_errors = 0;

  pak_name_charset_codec_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_char         (in_char),
    .in_first_char   (in_first_char),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_end_of_name (out_end_of_name)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic pnc_pkg::byte_t punct_at(input int idx);
    return PUNCT_SET[idx*8 +: 8];
  endfunction

  function automatic pnc_pkg::byte_t encode_char(input pnc_pkg::byte_t c);
    pnc_pkg::byte_t r;
    bit             hit;
    hit = 1'b0;
    r = pnc_pkg::ENC_OTHER;
    if (c < pnc_pkg::ASCII_SPC) begin
      r = NUL_CHAR;
      hit = 1'b1;
    end else if (c == pnc_pkg::ASCII_SPC) begin
      r = pnc_pkg::ENC_SPACE;
      hit = 1'b1;
    end
    for (int k = 0; k < pnc_pkg::PUNCT_COUNT; k++) begin
      if (!hit && c == punct_at(k)) begin
        r = pnc_pkg::PUNCT_BASE + pnc_pkg::byte_t'(k);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (c < pnc_pkg::ASCII_ZERO) r = pnc_pkg::ENC_LOW;
      else if (c <= pnc_pkg::ASCII_NINE) r = c - pnc_pkg::DIG_OFFS;
      else if (c >= pnc_pkg::ASCII_A && c <= pnc_pkg::ASCII_Z) r = c - pnc_pkg::CAP_OFFS;
    end
    return r;
  endfunction

  function automatic pnc_pkg::byte_t decode_char(input pnc_pkg::byte_t c);
    pnc_pkg::byte_t r;
    if (c < pnc_pkg::ENC_SPACE) r = pnc_pkg::DEC_OTHER;
    else if (c == pnc_pkg::ENC_SPACE) r = pnc_pkg::ASCII_SPC;
    else if (c < pnc_pkg::CODE_CAPA) r = c + pnc_pkg::DIG_OFFS;
    else if (c < pnc_pkg::PUNCT_BASE) r = c + pnc_pkg::CAP_OFFS;
    else if (c <= pnc_pkg::PUNCT_LAST) r = punct_at(int'(c - pnc_pkg::PUNCT_BASE));
    else r = pnc_pkg::DEC_OTHER;
    return r;
  endfunction

  // advance the zero latch and queue the bytes this item produces
  function automatic void convert_char(input logic mode, input pnc_pkg::byte_t c,
                                       input logic first, input logic last);
    pnc_pkg::byte_t r;
    if (first) zero_latch = 1'b0;
    if (c == NUL_CHAR) begin
      zero_latch = 1'b1;
      n_zero_bytes++;
    end
    if (zero_latch) r = NUL_CHAR;
    else if (mode == MODE_DEC) r = decode_char(c);
    else r = encode_char(c);
    if (mode == MODE_DEC && last) begin
      exp_chars.push_back('{ch: r, eon: 1'b0});
      exp_chars.push_back('{ch: NUL_CHAR, eon: 1'b1});
      n_terminators++;
    end else begin
      exp_chars.push_back('{ch: r, eon: last});
    end
  endfunction

  task automatic send_char(input logic mode, input pnc_pkg::byte_t c,
                           input logic first, input logic last);
    int gap;
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_char       <= c;
    in_first_char <= first;
    in_last_char  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    convert_char(mode, c, first, last);
    n_items++;
    gap = in_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // send a whole name in one direction, flags on the ends
  task automatic send_name(input logic mode, input pnc_pkg::byte_t chars[$]);
    for (int i = 0; i < chars.size(); i++)
      send_char(mode, chars[i], i == 0, i == chars.size() - 1);
  endtask

  function automatic pnc_pkg::byte_t pick_ascii();
    pnc_pkg::byte_t c;
    case ($urandom_range(0, 5))
      0: c = pnc_pkg::ASCII_A + pnc_pkg::byte_t'($urandom_range(0, 25));
      1: c = pnc_pkg::ASCII_ZERO + pnc_pkg::byte_t'($urandom_range(0, 9));
      2: c = punct_at($urandom_range(0, pnc_pkg::PUNCT_COUNT - 1));
      3: c = pnc_pkg::ASCII_SPC;
      default: c = pnc_pkg::byte_t'($urandom_range(1, 255));
    endcase
    return c;
  endfunction

  function automatic pnc_pkg::byte_t pick_code();
    pnc_pkg::byte_t c;
    case ($urandom_range(0, 5))
      0: c = pnc_pkg::CODE_CAPA + pnc_pkg::byte_t'($urandom_range(0, 25));
      1: c = pnc_pkg::CODE_DIG0 + pnc_pkg::byte_t'($urandom_range(0, 9));
      2: c = pnc_pkg::PUNCT_BASE
             + pnc_pkg::byte_t'($urandom_range(0, pnc_pkg::PUNCT_COUNT - 1));
      3: c = pnc_pkg::ENC_SPACE;
      4: c = pnc_pkg::byte_t'($urandom_range(1, 14));
      default: c = pnc_pkg::byte_t'($urandom_range(1, 255));
    endcase
    return c;
  endfunction

  task automatic test_encode_classes();
    send_name(MODE_ENC, '{8'h20, 8'h21, 8'h40, 8'h3A, 8'h24, 8'h30, 8'h39,
                         8'h3B, 8'h41, 8'h5A, 8'h5B, 8'h1F, 8'hFF});
  endtask

  task automatic test_decode_classes();
    send_name(MODE_DEC, '{8'h01, 8'h0F, 8'h10, 8'h19, 8'h1A, 8'h33, 8'h34,
                         8'h41, 8'h42, 8'hFF});
  endtask

  task automatic test_zero_latch();
    // a zero ends the name; the latch holds until a first byte
    send_char(MODE_ENC, pnc_pkg::ASCII_A, 1'b1, 1'b0);
    send_char(MODE_ENC, NUL_CHAR, 1'b0, 1'b0);
    send_char(MODE_DEC, pnc_pkg::CODE_CAPA, 1'b0, 1'b1);
    send_char(MODE_ENC, pnc_pkg::ASCII_Z, 1'b0, 1'b1);
    send_char(MODE_DEC, pnc_pkg::CODE_DIG0, 1'b1, 1'b1);
  endtask

  task automatic test_random_names();
    int             stop_at;
    int             len;
    logic           mode;
    logic           first;
    logic           last;
    bit             broken;
    pnc_pkg::byte_t c;
    stop_at = n_items + RANDOM_ITEMS;
    while (n_items < stop_at) begin
      if ($urandom_range(0, 19) == 0) begin
        in_gaps  = $urandom_range(0, 2) != 0;
        out_gaps = $urandom_range(0, 2) != 0;
      end
      len = $urandom_range(1, 12);
      mode = 1'($urandom_range(0, 1));
      broken = $urandom_range(0, 9) == 0;
      for (int i = 0; i < len; i++) begin
        c = (mode == MODE_DEC) ? pick_code() : pick_ascii();
        if ($urandom_range(0, 29) == 0) c = NUL_CHAR;
        first = (i == 0);
        last = (i == len - 1);
        if (broken) begin
          first = 1'($urandom_range(0, 1));
          last = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 3) == 0) mode = ~mode;
        end
        send_char(mode, c, first, last);
      end
    end
  endtask

  // take each result item, compare it and draw the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (exp_chars.size() == 0) begin
          $error("unexpected result: out_char %h, out_end_of_name %b",
                 out_char, out_end_of_name);
          n_errors++;
        end else begin
          want = exp_chars.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, out_char);
            n_errors++;
          end
          if (out_end_of_name !== want.eon) begin
            $error("out_end_of_name: expected %b, got %b", want.eon,
                   out_end_of_name);
            n_errors++;
          end
        end
        hold_left = out_gaps ? $urandom_range(0, MAX_GAP) : 0;
      end else if (out_valid && out_stall && hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("tb_pak_name_charset_codec_unit NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_encode_classes();
    test_decode_classes();
    test_zero_latch();
    test_random_names();
    in_valid <= 1'b0;
    while (exp_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items in both modes, %0d result items checked",
             n_items, n_results);
    $display("%0d decode terminators, %0d zero bytes, %0d mismatches",
             n_terminators, n_zero_bytes, n_errors);
    if (n_errors == 0) begin
      $display("tb_pak_name_charset_codec_unit OK");
    end else begin
      $display("tb_pak_name_charset_codec_unit NOT OK");
    end
    $finish;
  end

endmodule
